### sv/sts_pkg.sv
package sts_pkg;

  // Operation codes carried in the func field of an input beat.
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_LINEAR = 2'd1;
  localparam logic [1:0] FUNC_BINARY = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 10;

  // One input beat.
  typedef struct packed {
    logic [1:0]               func;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } sts_in_t;

  // One result beat.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } sts_out_t;

  // Sequencer states of the search engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_BIN,
    ST_BFIN,
    ST_RES
  } sts_state_t;

endpackage

### sv/sts_ram.sv
module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/sts_engine.sv
module sts_engine
  import sts_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  sts_in_t                    in_data,
  output logic                       in_stall,
  input  logic                       slot_free,
  output logic                       push,
  output sts_out_t                   res,
  output logic                       ram_we,
  output logic [$clog2(ENTRIES)-1:0] ram_waddr,
  output logic [DATA_W-1:0]          ram_wdata,
  output logic                       ram_re,
  output logic [$clog2(ENTRIES)-1:0] ram_raddr,
  input  logic [DATA_W-1:0]          ram_rdata
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  sts_state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic          chk_last_r, chk_last_nxt;
  logic [AW-1:0] chk_pos_r, chk_pos_nxt;
  sts_out_t      res_r, res_nxt;

  logic          idx_ok;
  logic          gt;
  logic          eq;
  logic [AW-1:0] lo_n;
  logic [AW-1:0] hi_n;
  logic [AW:0]   sum_n;
  logic [AW:0]   sum_init;

  // A write beyond the table is dropped.
  assign idx_ok   = (32'(in_data.index) < 32'(ENTRIES));
  assign eq       = (ram_rdata == key_r);
  assign gt       = (key_r > $signed(ram_rdata));
  assign lo_n     = gt ? AW'({1'b0, mid_r} + (AW + 1)'(1)) : lo_r;
  assign hi_n     = gt ? hi_r : mid_r;
  assign sum_n    = {1'b0, lo_n} + {1'b0, hi_n};
  assign sum_init = {1'b0, LAST};
  assign res      = res_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the current search.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    scan_r     <= scan_nxt;
    iss_done_r <= iss_done_nxt;
    chk_v_r    <= chk_v_nxt;
    chk_last_r <= chk_last_nxt;
    chk_pos_r  <= chk_pos_nxt;
    res_r      <= res_nxt;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    scan_nxt     = scan_r;
    iss_done_nxt = iss_done_r;
    chk_v_nxt    = chk_v_r;
    chk_last_nxt = chk_last_r;
    chk_pos_nxt  = chk_pos_r;
    res_nxt      = res_r;
    // No beat is taken while reset is held.
    in_stall     = !rst_n || (state_r != ST_IDLE);
    push         = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(in_data.index);
    ram_wdata    = in_data.value;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          case (in_data.func)
            FUNC_WRITE: begin
              ram_we = idx_ok;
            end
            FUNC_LINEAR: begin
              // Position zero is read now; the scan continues from one.
              key_nxt      = in_data.value;
              ram_re       = 1'b1;
              ram_raddr    = '0;
              chk_v_nxt    = 1'b1;
              chk_pos_nxt  = '0;
              chk_last_nxt = 1'b0;
              scan_nxt     = AW'(1);
              iss_done_nxt = 1'b0;
              state_nxt    = ST_LIN;
            end
            FUNC_BINARY: begin
              // The first probe covers the whole table.
              key_nxt   = in_data.value;
              lo_nxt    = '0;
              hi_nxt    = LAST;
              mid_nxt   = sum_init[AW:1];
              ram_re    = 1'b1;
              ram_raddr = sum_init[AW:1];
              state_nxt = ST_BIN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LIN: begin
        // Issue the next address while the previous read is checked.
        if (!iss_done_r) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_r;
          chk_v_nxt    = 1'b1;
          chk_pos_nxt  = scan_r;
          chk_last_nxt = (scan_r == LAST);
          scan_nxt     = scan_r + AW'(1);
          iss_done_nxt = (scan_r == LAST);
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r) begin
          if (eq) begin
            res_nxt.found    = 1'b1;
            res_nxt.position = IDX_W'(chk_pos_r);
            state_nxt        = ST_RES;
          end else if (chk_last_r) begin
            res_nxt.found    = 1'b0;
            res_nxt.position = '0;
            state_nxt        = ST_RES;
          end
        end
      end

      ST_BIN: begin
        // Narrow the range and issue the next probe in the same cycle.
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        ram_re = 1'b1;
        if (lo_n < hi_n) begin
          mid_nxt   = sum_n[AW:1];
          ram_raddr = sum_n[AW:1];
        end else begin
          ram_raddr = lo_n;
          state_nxt = ST_BFIN;
        end
      end

      ST_BFIN: begin
        // The final entry decides the match.
        res_nxt.found    = eq;
        res_nxt.position = eq ? IDX_W'(lo_r) : '0;
        state_nxt        = ST_RES;
      end

      ST_RES: begin
        push = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sorted_table_search.sv
// Table of ENTRIES signed 32-bit words with write, linear search and binary
// (lower-bound) search beats. One beat is handled at a time. A write is
// stored as its beat is taken. A binary search issues its first probe when
// the beat is taken, then halves the range with each further probe, tests
// the final entry and hands the result to the output register. The table
// memory has one registered read port, and the sequencer makes one probe per
// cycle. A linear search reads the entries in order from position zero, one
// entry per cycle through the same read port, and ends at the first match or
// after the last entry. Entries must be written before any search reads
// them. A result beat waits in an output register, and a new input beat may
// be taken while it waits; a search that finishes while that register is
// still full holds the input side stalled until the waiting beat leaves. No
// beat is taken during reset.
module sorted_table_search
  import sts_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sts_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sts_out_t out_data
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              slot_free;
  logic              push;
  sts_out_t          res;
  logic              out_valid_r;
  sts_out_t          out_data_r;

  sts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sts_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .slot_free (slot_free),
    .push      (push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // The output register is free when empty or when its beat leaves now.
  assign slot_free = !out_valid_r || !out_stall;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/sts_checker.sv
module sts_checker
  import sts_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input sts_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input sts_out_t out_data
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("miss with non-zero position");

  // A search keeps the input side stalled on the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.func == FUNC_LINEAR || in_data.func == FUNC_BINARY) |=> in_stall)
    else $error("input taken while a search runs");

  // A write beat does not hold the input side stalled.
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func == FUNC_WRITE |=> !in_stall)
    else $error("write beat held the input side");

endmodule

bind sorted_table_search sts_checker u_sts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
